// ----- hdl/trs_pkg.sv -----
// shared types, widths and codes for the touch event rotate and scale unit
package trs_pkg;

  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 800;

  localparam int PX_W        = 9;
  localparam int PY_W        = 10;
  localparam int AXIS_W      = 16;
  localparam int VALUE_W     = 32;
  localparam int TIME_W      = 32;
  localparam int TYPE_W      = 16;
  localparam int CODE_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUO_W       = 10;
  localparam int DIVISOR_W   = AXIS_W;
  localparam int DIVIDEND_W  = VALUE_W + QUO_W;
  localparam int REM_W       = DIVISOR_W + QUO_W;
  localparam int CNT_W       = $clog2(QUO_W);

  localparam logic [PX_W-1:0]  PX_MAX = PX_W'(SCREEN_WIDTH - 1);
  localparam logic [PY_W-1:0]  PY_MAX = PY_W'(SCREEN_HEIGHT - 1);
  localparam logic [AXIS_W-1:0] RANGE_FALLBACK = AXIS_W'(4095);

  localparam logic [TYPE_W-1:0] EVT_KEY    = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] EVT_ABS    = TYPE_W'(3);
  localparam logic [CODE_W-1:0] CODE_X     = CODE_W'('h00);
  localparam logic [CODE_W-1:0] CODE_Y     = CODE_W'('h01);
  localparam logic [CODE_W-1:0] CODE_MT_X  = CODE_W'('h35);
  localparam logic [CODE_W-1:0] CODE_MT_Y  = CODE_W'('h36);
  localparam logic [CODE_W-1:0] CODE_TRACK = CODE_W'('h39);
  localparam logic [CODE_W-1:0] CODE_TOUCH = CODE_W'('h14a);

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = CFG_IDX_W'(3);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } trs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic             saturated;
  } trs_div_rsp_t;

endpackage

// ----- hdl/trs_if.sv -----
// valid/ready channel interfaces for events, points and register writes
interface trs_in_if;
  import trs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [TYPE_W-1:0]         event_type;
  logic [CODE_W-1:0]         event_code;
  logic signed [VALUE_W-1:0] event_value;
  logic [TIME_W-1:0]         time_ms;
  modport source (output valid, operation, event_type, event_code, event_value, time_ms,
                  input ready);
  modport sink (input valid, operation, event_type, event_code, event_value, time_ms,
                output ready);
endinterface

interface trs_out_if;
  import trs_pkg::*;
  logic              valid;
  logic              ready;
  logic [PX_W-1:0]   point_x;
  logic [PY_W-1:0]   point_y;
  logic              point_pressed;
  logic [TIME_W-1:0] touch_time_ms;
  modport source (output valid, point_x, point_y, point_pressed, touch_time_ms,
                  input ready);
  modport sink (input valid, point_x, point_y, point_pressed, touch_time_ms,
                output ready);
endinterface

interface trs_cfg_if;
  import trs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [AXIS_W-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ----- hdl/touch_event_rotate_scale_unit.sv -----
// top level: touch state, axis registers, read sequencer and output register
// Event beats (operation 0) are taken while idle and update the latched raw position,
// the pressed flag and the activity stamp. A read beat (operation 1) starts a sequence that,
// for each portrait axis, applies offset and constant multiply, starts the shared divider
// and waits while the divider resolves ten quotient bits, one per cycle; a final state
// loads the result register. The input is not ready during the read sequence or while
// a finished point waits for the output register to free up.
// Register writes are taken in any cycle and should only be issued while the unit is idle.
module touch_event_rotate_scale_unit (
  input logic clk,
  input logic rst_n,
  trs_in_if.sink    in_chan,
  trs_out_if.source out_chan,
  trs_cfg_if.sink   cfg_chan
);
  import trs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_Y  = 3'd1;
  localparam logic [2:0] S_DIV_Y  = 3'd2;
  localparam logic [2:0] S_WAIT_Y = 3'd3;
  localparam logic [2:0] S_MUL_X  = 3'd4;
  localparam logic [2:0] S_DIV_X  = 3'd5;
  localparam logic [2:0] S_WAIT_X = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic signed [AXIS_W-1:0]  x_min_r, x_min_nxt, x_max_r, x_max_nxt;
  logic signed [AXIS_W-1:0]  y_min_r, y_min_nxt, y_max_r, y_max_nxt;
  logic signed [VALUE_W-1:0] raw_x_r, raw_x_nxt, raw_y_r, raw_y_nxt;
  logic                      down_r, down_nxt;
  logic [TIME_W-1:0]         stamp_r, stamp_nxt;
  logic [DIVIDEND_W-1:0]     prod_r, prod_nxt;
  logic [DIVISOR_W-1:0]      range_r, range_nxt;
  logic                      neg_r, neg_nxt;
  logic [PX_W-1:0]           px_r, px_nxt;
  logic [PY_W-1:0]           py_r, py_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PX_W-1:0]           out_x_r, out_x_nxt;
  logic [PY_W-1:0]           out_y_r, out_y_nxt;
  logic                      out_pressed_r, out_pressed_nxt;
  logic [TIME_W-1:0]         out_stamp_r, out_stamp_nxt;

  logic                  in_fire;
  logic                  axis_x;
  logic signed [AXIS_W-1:0]  sel_min, sel_max;
  logic signed [VALUE_W-1:0] sel_raw;
  logic signed [AXIS_W:0]    span;
  logic signed [VALUE_W:0]   offset;
  logic [QUO_W-1:0]      mul_k;
  logic                  out_load;
  trs_div_req_t          div_req;
  trs_div_rsp_t          div_rsp;

  trs_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_load       = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    axis_x  = (state_r == S_MUL_X);
    sel_min = axis_x ? x_min_r : y_min_r;
    sel_max = axis_x ? x_max_r : y_max_r;
    sel_raw = axis_x ? raw_x_r : raw_y_r;
    mul_k   = axis_x ? PY_MAX : QUO_W'(PX_MAX);
    span    = {sel_max[AXIS_W-1], sel_max} - {sel_min[AXIS_W-1], sel_min};
    offset  = {sel_raw[VALUE_W-1], sel_raw} - (VALUE_W+1)'(sel_min);
    div_req.start    = (state_r == S_DIV_Y) || (state_r == S_DIV_X);
    div_req.dividend = prod_r;
    div_req.divisor  = range_r;
  end

  always_comb begin
    state_nxt       = state_r;
    x_min_nxt       = x_min_r;
    x_max_nxt       = x_max_r;
    y_min_nxt       = y_min_r;
    y_max_nxt       = y_max_r;
    raw_x_nxt       = raw_x_r;
    raw_y_nxt       = raw_y_r;
    down_nxt        = down_r;
    stamp_nxt       = stamp_r;
    prod_nxt        = prod_r;
    range_nxt       = range_r;
    neg_nxt         = neg_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    out_valid_nxt   = out_valid_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_pressed_nxt = out_pressed_r;
    out_stamp_nxt   = out_stamp_r;

    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_X_MIN: x_min_nxt = cfg_chan.wdata;
        REG_X_MAX: x_max_nxt = cfg_chan.wdata;
        REG_Y_MIN: y_min_nxt = cfg_chan.wdata;
        REG_Y_MAX: y_max_nxt = cfg_chan.wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.operation == OP_READ) begin
            state_nxt = S_MUL_Y;
          end else if (in_chan.event_type == EVT_ABS) begin
            if (in_chan.event_code == CODE_X || in_chan.event_code == CODE_MT_X)
              raw_x_nxt = in_chan.event_value;
            else if (in_chan.event_code == CODE_Y || in_chan.event_code == CODE_MT_Y)
              raw_y_nxt = in_chan.event_value;
            else if (in_chan.event_code == CODE_TRACK)
              down_nxt = !in_chan.event_value[VALUE_W-1];
            stamp_nxt = in_chan.time_ms;
          end else if (in_chan.event_type == EVT_KEY && in_chan.event_code == CODE_TOUCH) begin
            down_nxt  = !in_chan.event_value[VALUE_W-1] && (in_chan.event_value != '0);
            stamp_nxt = in_chan.time_ms;
          end
        end
      end
      S_MUL_Y, S_MUL_X: begin
        neg_nxt   = offset[VALUE_W];
        prod_nxt  = DIVIDEND_W'(offset[VALUE_W-1:0]) * DIVIDEND_W'(mul_k);
        range_nxt = (span[AXIS_W] || span == '0) ? RANGE_FALLBACK : span[AXIS_W-1:0];
        state_nxt = axis_x ? S_DIV_X : S_DIV_Y;
      end
      S_DIV_Y: state_nxt = S_WAIT_Y;
      S_DIV_X: state_nxt = S_WAIT_X;
      S_WAIT_Y: begin
        if (div_rsp.done) begin
          if (neg_r)
            px_nxt = '0;
          else if (div_rsp.saturated || div_rsp.quotient > QUO_W'(PX_MAX))
            px_nxt = PX_MAX;
          else
            px_nxt = div_rsp.quotient[PX_W-1:0];
          state_nxt = S_MUL_X;
        end
      end
      S_WAIT_X: begin
        if (div_rsp.done) begin
          if (neg_r)
            py_nxt = PY_MAX;
          else if (div_rsp.saturated || div_rsp.quotient > PY_MAX)
            py_nxt = '0;
          else
            py_nxt = PY_MAX - div_rsp.quotient;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt   = 1'b1;
          out_x_nxt       = px_r;
          out_y_nxt       = py_r;
          out_pressed_nxt = down_r;
          out_stamp_nxt   = stamp_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_min_r     <= '0;
      x_max_r     <= RANGE_FALLBACK;
      y_min_r     <= '0;
      y_max_r     <= RANGE_FALLBACK;
      raw_x_r     <= '0;
      raw_y_r     <= '0;
      down_r      <= 1'b0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_min_r     <= x_min_nxt;
      x_max_r     <= x_max_nxt;
      y_min_r     <= y_min_nxt;
      y_max_r     <= y_max_nxt;
      raw_x_r     <= raw_x_nxt;
      raw_y_r     <= raw_y_nxt;
      down_r      <= down_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r        <= prod_nxt;
    range_r       <= range_nxt;
    neg_r         <= neg_nxt;
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_pressed_r <= out_pressed_nxt;
    out_stamp_r   <= out_stamp_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.point_x       = out_x_r;
  assign out_chan.point_y       = out_y_r;
  assign out_chan.point_pressed = out_pressed_r;
  assign out_chan.touch_time_ms = out_stamp_r;

  a_point_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r <= PX_MAX) && (out_y_r <= PY_MAX))
    else $error("point outside the screen");
  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT_Y) || (state_r == S_WAIT_X))
    else $error("divider result with no axis waiting");
  a_read_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.operation == OP_READ) |=> state_r == S_MUL_Y)
    else $error("read beat did not start the sequence");

endmodule

// ----- hdl/trs_div_unit.sv -----
// iterative restoring divider with ten bit quotient and a saturation flag
module trs_div_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trs_pkg::trs_div_req_t req,
  output trs_pkg::trs_div_rsp_t rsp
);
  import trs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [REM_W-2:0]     dsh_r, dsh_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic                 sat_r, sat_nxt;
  logic                 ge;
  logic [REM_W-1:0]     diff;

  always_comb begin
    ge       = rem_r >= {1'b0, dsh_r};
    diff     = rem_r - {1'b0, dsh_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    sat_nxt  = sat_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = req.dividend[REM_W-1:0];
      dsh_nxt  = {req.divisor, {(QUO_W-1){1'b0}}};
      quo_nxt  = '0;
      sat_nxt  = req.dividend >= {{(DIVIDEND_W-REM_W){1'b0}}, req.divisor, {QUO_W{1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt        = diff;
        quo_nxt[cnt_r] = 1'b1;
      end
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.saturated = sat_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("divider done without a run");

endmodule
